/* hdl/servo_reply_frame_checker_assert.svh */
// Assertion macros shared by the servo reply frame checker RTL.
// Each macro expands to one labeled concurrent assertion that reports through $error.
`ifndef SERVO_REPLY_FRAME_CHECKER_ASSERT_SVH
`define SERVO_REPLY_FRAME_CHECKER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SRFC_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("srfc assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SRFC_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("srfc assertion failed");

// The expression must hold at every clock edge outside reset.
`define SRFC_ASSERT_ALW(name, clk, rst_n, expr) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("srfc assertion failed");

`endif

/* hdl/srfc_pkg.sv */
// Types and constants of the servo reply frame checker.
// Has no dependencies; used by every module of the block.
`default_nettype none

package srfc_pkg;

    localparam logic [3:0] HUNT_LIMIT     = 4'd10;
    localparam logic [1:0] MAX_DATA_BYTES = 2'd2;
    localparam logic [7:0] SYNC_BYTE      = 8'hFF;
    localparam logic [7:0] BROADCAST_ID   = 8'hFE;

    typedef enum logic [1:0] {
        ACT_START   = 2'd0,
        ACT_BYTE    = 2'd1,
        ACT_TIMEOUT = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_HUNT = 2'd1,
        PH_BODY = 2'd2
    } phase_t;

    typedef enum logic [2:0] {
        ERR_OK       = 3'd0,
        ERR_NO_REPLY = 3'd1,
        ERR_CHECKSUM = 3'd2,
        ERR_ID       = 3'd3,
        ERR_LENGTH   = 3'd4
    } err_t;

    typedef struct packed {
        action_t    action;
        logic [7:0] rx_byte;
        logic [7:0] expected_id;
        logic [1:0] data_length;
    } item_t;

    typedef struct packed {
        err_t        error_code;
        logic [7:0]  servo_status;
        logic [15:0] data_value;
    } result_t;

endpackage

`default_nettype wire

/* hdl/servo_reply_frame_checker.sv */
// Servo reply frame checker top level; depends on srfc_pkg and the srfc_* modules.
// A result goes from the input register through the result register onto m_valid.
// Throughput: one input transfer per cycle, limited only by the one-entry result register.
// Reset: aresetn is synchronous and active low; it empties both registers and returns
// the parser to idle with all captured fields cleared.
`default_nettype none

module servo_reply_frame_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_action,
    input  wire logic [7:0]  s_rx_byte,
    input  wire logic [7:0]  s_expected_id,
    input  wire logic [1:0]  s_data_length,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [2:0]       m_error_code,
    output logic [7:0]       m_servo_status,
    output logic [15:0]      m_data_value
);

    srfc_pkg::item_t   s_item;
    srfc_pkg::item_t   item;
    logic              item_valid;
    logic              item_take;
    logic              out_free;
    logic              res_load;
    srfc_pkg::result_t res;
    srfc_pkg::result_t m_res;

    assign s_item.action      = srfc_pkg::action_t'(s_action);
    assign s_item.rx_byte     = s_rx_byte;
    assign s_item.expected_id = s_expected_id;
    assign s_item.data_length = s_data_length;

    srfc_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .item_take  (item_take),
        .item_valid (item_valid),
        .item       (item)
    );

    srfc_parser u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_valid),
        .item       (item),
        .out_free   (out_free),
        .item_take  (item_take),
        .res_load   (res_load),
        .res        (res)
    );

    srfc_out_reg u_out_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .res_load (res_load),
        .res      (res),
        .out_free (out_free),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_res    (m_res)
    );

    assign m_error_code   = m_res.error_code;
    assign m_servo_status = m_res.servo_status;
    assign m_data_value   = m_res.data_value;

endmodule

`default_nettype wire

/* hdl/srfc_in_reg.sv */
// Input register of the servo reply frame checker.
// Holds one accepted transfer until the parser takes it; uses srfc_pkg.
`default_nettype none

module srfc_in_reg (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  wire srfc_pkg::item_t s_item,
    input  wire logic            item_take,
    output logic                 item_valid,
    output srfc_pkg::item_t      item
);

    logic            valid_reg;
    logic            valid_next;
    srfc_pkg::item_t item_reg;
    logic            accept;

    assign s_ready    = !valid_reg || item_take;
    assign accept     = s_valid && s_ready;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb begin
        if (accept) begin
            valid_next = 1'b1;
        end else if (item_take) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg <= s_item;
        end
    end

endmodule

`default_nettype wire

/* hdl/srfc_parser.sv */
// Frame parser of the servo reply frame checker: header hunt, body capture and checks.
// Depends on srfc_pkg and servo_reply_frame_checker_assert.svh.
`default_nettype none
`include "servo_reply_frame_checker_assert.svh"

module srfc_parser (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            item_valid,
    input  wire srfc_pkg::item_t item,
    input  wire logic            out_free,
    output logic                 item_take,
    output logic                 res_load,
    output srfc_pkg::result_t    res
);

    srfc_pkg::phase_t phase_reg, phase_next;
    logic [7:0]  previous_byte_reg, previous_byte_next;
    logic [3:0]  hunt_count_reg, hunt_count_next;
    logic [2:0]  body_index_reg, body_index_next;
    logic [7:0]  want_id_reg, want_id_next;
    logic [1:0]  want_length_reg, want_length_next;
    logic [7:0]  got_id_reg, got_id_next;
    logic [7:0]  got_length_reg, got_length_next;
    logic [7:0]  got_status_reg, got_status_next;
    logic [15:0] data_word_reg, data_word_next;
    logic [7:0]  running_sum_reg, running_sum_next;

    logic            fire;
    logic            header_hit;
    logic            hunt_over;
    logic [2:0]      body_end;
    logic            body_last;
    logic            id_bad;
    logic            len_bad;
    logic            sum_bad;
    logic [1:0]      start_length;
    srfc_pkg::err_t  finish_code;

    assign fire      = item_valid && out_free;
    assign item_take = fire;

    assign header_hit = (previous_byte_reg == srfc_pkg::SYNC_BYTE)
                     && (item.rx_byte == srfc_pkg::SYNC_BYTE);
    assign hunt_over  = hunt_count_reg >= srfc_pkg::HUNT_LIMIT;
    assign body_end   = {1'b0, want_length_reg} + 3'd3;
    assign body_last  = body_index_reg == body_end;
    assign id_bad     = (got_id_reg != want_id_reg) && (want_id_reg != srfc_pkg::BROADCAST_ID);
    assign len_bad    = got_length_reg != ({6'd0, want_length_reg} + 8'd2);
    assign sum_bad    = (~running_sum_reg) != item.rx_byte;
    assign start_length = (item.data_length > srfc_pkg::MAX_DATA_BYTES)
                        ? srfc_pkg::MAX_DATA_BYTES : item.data_length;

    always_comb begin
        priority if (id_bad) begin
            finish_code = srfc_pkg::ERR_ID;
        end else if (len_bad) begin
            finish_code = srfc_pkg::ERR_LENGTH;
        end else if (sum_bad) begin
            finish_code = srfc_pkg::ERR_CHECKSUM;
        end else begin
            finish_code = srfc_pkg::ERR_OK;
        end
    end

    // Next-state logic.
    always_comb begin
        phase_next         = phase_reg;
        previous_byte_next = previous_byte_reg;
        hunt_count_next    = hunt_count_reg;
        body_index_next    = body_index_reg;
        want_id_next       = want_id_reg;
        want_length_next   = want_length_reg;
        got_id_next        = got_id_reg;
        got_length_next    = got_length_reg;
        got_status_next    = got_status_reg;
        data_word_next     = data_word_reg;
        running_sum_next   = running_sum_reg;
        if (fire) begin
            unique case (item.action)
                srfc_pkg::ACT_START: begin
                    phase_next         = srfc_pkg::PH_HUNT;
                    want_id_next       = item.expected_id;
                    want_length_next   = start_length;
                    previous_byte_next = 8'd0;
                    hunt_count_next    = 4'd0;
                    body_index_next    = 3'd0;
                    got_id_next        = 8'd0;
                    got_length_next    = 8'd0;
                    got_status_next    = 8'd0;
                    data_word_next     = 16'd0;
                    running_sum_next   = 8'd0;
                end
                srfc_pkg::ACT_TIMEOUT: begin
                    phase_next = srfc_pkg::PH_IDLE;
                end
                srfc_pkg::ACT_BYTE: begin
                    unique case (phase_reg)
                        srfc_pkg::PH_HUNT: begin
                            if (header_hit) begin
                                phase_next       = srfc_pkg::PH_BODY;
                                body_index_next  = 3'd0;
                                running_sum_next = 8'd0;
                                data_word_next   = 16'd0;
                            end else begin
                                previous_byte_next = item.rx_byte;
                                if (hunt_over) begin
                                    phase_next = srfc_pkg::PH_IDLE;
                                end else begin
                                    hunt_count_next = hunt_count_reg + 4'd1;
                                end
                            end
                        end
                        srfc_pkg::PH_BODY: begin
                            if (body_last) begin
                                phase_next = srfc_pkg::PH_IDLE;
                            end else begin
                                unique case (body_index_reg)
                                    3'd0: got_id_next = item.rx_byte;
                                    3'd1: got_length_next = item.rx_byte;
                                    3'd2: got_status_next = item.rx_byte;
                                    3'd3: data_word_next = {data_word_reg[15:8], item.rx_byte};
                                    default: data_word_next = {item.rx_byte, data_word_reg[7:0]};
                                endcase
                                running_sum_next = running_sum_reg + item.rx_byte;
                                body_index_next  = body_index_reg + 3'd1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                default: begin
                end
            endcase
        end
    end

    // Result logic.
    always_comb begin
        res_load         = 1'b0;
        res.error_code   = srfc_pkg::ERR_OK;
        res.servo_status = 8'd0;
        res.data_value   = 16'd0;
        if (fire) begin
            unique case (item.action)
                srfc_pkg::ACT_TIMEOUT: begin
                    if (phase_reg != srfc_pkg::PH_IDLE) begin
                        res_load       = 1'b1;
                        res.error_code = srfc_pkg::ERR_NO_REPLY;
                    end
                end
                srfc_pkg::ACT_BYTE: begin
                    if ((phase_reg == srfc_pkg::PH_HUNT) && !header_hit && hunt_over) begin
                        res_load       = 1'b1;
                        res.error_code = srfc_pkg::ERR_NO_REPLY;
                    end else if ((phase_reg == srfc_pkg::PH_BODY) && body_last) begin
                        res_load       = 1'b1;
                        res.error_code = finish_code;
                        if (finish_code == srfc_pkg::ERR_OK) begin
                            res.servo_status = got_status_reg;
                            res.data_value   = (want_length_reg == 2'd0) ? 16'd0 : data_word_reg;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg         <= srfc_pkg::PH_IDLE;
            previous_byte_reg <= 8'd0;
            hunt_count_reg    <= 4'd0;
            body_index_reg    <= 3'd0;
            want_id_reg       <= 8'd0;
            want_length_reg   <= 2'd0;
            got_id_reg        <= 8'd0;
            got_length_reg    <= 8'd0;
            got_status_reg    <= 8'd0;
            data_word_reg     <= 16'd0;
            running_sum_reg   <= 8'd0;
        end else begin
            phase_reg         <= phase_next;
            previous_byte_reg <= previous_byte_next;
            hunt_count_reg    <= hunt_count_next;
            body_index_reg    <= body_index_next;
            want_id_reg       <= want_id_next;
            want_length_reg   <= want_length_next;
            got_id_reg        <= got_id_next;
            got_length_reg    <= got_length_next;
            got_status_reg    <= got_status_next;
            data_word_reg     <= data_word_next;
            running_sum_reg   <= running_sum_next;
        end
    end

    `SRFC_ASSERT_NXT(a_idle_after_result, aclk, aresetn, res_load, phase_reg == srfc_pkg::PH_IDLE)
    `SRFC_ASSERT_ALW(a_hunt_bound, aclk, aresetn, hunt_count_reg <= srfc_pkg::HUNT_LIMIT)
    `SRFC_ASSERT_IMP(a_body_bound, aclk, aresetn, phase_reg == srfc_pkg::PH_BODY, body_index_reg <= body_end)
    `SRFC_ASSERT_IMP(a_error_clears, aclk, aresetn, res_load && (res.error_code != srfc_pkg::ERR_OK), (res.servo_status == 8'd0) && (res.data_value == 16'd0))

endmodule

`default_nettype wire

/* hdl/srfc_out_reg.sv */
// Result register of the servo reply frame checker.
// Holds one result transfer until the consumer takes it; uses srfc_pkg.
`default_nettype none

module srfc_out_reg (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              res_load,
    input  wire srfc_pkg::result_t res,
    output logic                   out_free,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output srfc_pkg::result_t      m_res
);

    logic              valid_reg;
    logic              valid_next;
    srfc_pkg::result_t res_reg;

    assign out_free = !valid_reg || m_ready;
    assign m_valid  = valid_reg;
    assign m_res    = res_reg;

    always_comb begin
        if (res_load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_load) begin
            res_reg <= res;
        end
    end

endmodule

`default_nettype wire
